// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define KTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define KTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/kti_pkg.sv -----
// shared constants and types of the keyframe track interpolator
`timescale 1ns / 1ps
package kti_pkg;

	localparam int KEY_DEPTH = 256;
	localparam int FRAC_BITS = 16;

	localparam int IDX_W   = $clog2(KEY_DEPTH);
	localparam int COMP_W  = 32;
	localparam int TIME_W  = 32;
	localparam int KIDX_W  = 8;
	localparam int KCNT_W  = 9;
	localparam int VEC_N   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP_EN  = 1'd1;

	// item operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [VEC_N-1:0][COMP_W-1:0] key_vec_t;

endpackage

// ----- hw/rtl/kti_item_if.sv -----
// input channel of the interpolator: key writes and queries
`timescale 1ns / 1ps
interface kti_item_if import kti_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [KIDX_W-1:0]        key_index;
	logic [TIME_W-1:0]        key_time;
	logic signed [COMP_W-1:0] key_x;
	logic signed [COMP_W-1:0] key_y;
	logic signed [COMP_W-1:0] key_z;
	logic [TIME_W-1:0]        sample_time;

	modport source (
		output valid, op, key_index, key_time, key_x, key_y, key_z, sample_time,
		input  ready
	);
	modport sink (
		input  valid, op, key_index, key_time, key_x, key_y, key_z, sample_time,
		output ready
	);
endinterface

// ----- hw/rtl/kti_result_if.sv -----
// output channel of the interpolator: one sampled vector per item
`timescale 1ns / 1ps
interface kti_result_if import kti_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     valid_res;
	logic [KIDX_W-1:0]        before_index;
	logic [KIDX_W-1:0]        after_index;
	logic signed [COMP_W-1:0] out_x;
	logic signed [COMP_W-1:0] out_y;
	logic signed [COMP_W-1:0] out_z;

	modport source (
		output valid, valid_res, before_index, after_index, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, valid_res, before_index, after_index, out_x, out_y, out_z,
		output ready
	);
endinterface

// ----- hw/rtl/keyframe_track_interpolator.sv -----
// Keyframe track interpolator: one track of up to 256 keys (32-bit time, three signed
// Q16.16 components) in two-port tables. A write item (op 0) stores one key and
// returns an all-zero result. A query item (op 1) binary-searches the first key_count
// keys for the pair bracketing sample_time and returns the earlier key, or the linear
// blend of both with the fraction clamped to 0..1. Exactly one result per item, in
// order. The block takes one item at a time: writes and empty-track queries go
// straight to the result register; a query runs the search in 1 to 8 steps (about
// log2 of key_count) and reads the two keys; a blend uses the divider only when the
// fraction lies strictly between 0 and 1. The search reads the time table once a
// cycle, the fraction comes from a restoring divider at one quotient bit a cycle,
// and one multiplier serves the three components in turn. A finished result waits
// in an output register while the next item is already being taken. The user must
// have registers key_count and interpolate_enable written only while the block is
// idle; the block does not enforce this. Entries never written read as undefined.
`timescale 1ns / 1ps
module keyframe_track_interpolator import kti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	kti_item_if.sink              item,
	kti_result_if.source          result
);

	localparam int CNT_W  = $clog2(FRAC_BITS);
	localparam int LANE_W = $clog2(VEC_N);
	localparam int PROD_W = COMP_W + FRAC_BITS + 3;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_RDA, S_LATA, S_PREP, S_CLAMP, S_DIV, S_MUL, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [KCNT_W-1:0] key_count_q;
	logic              interp_q;

	// key tables
	logic [TIME_W-1:0] time_mem [KEY_DEPTH];
	key_vec_t          vec_mem  [KEY_DEPTH];
	logic [IDX_W-1:0]  rd_addr;
	logic [TIME_W-1:0] rd_time_q;
	key_vec_t          rd_vec_q;

	// working registers
	logic [TIME_W-1:0]      t_q;
	logic [IDX_W-1:0]       lo_q, hi_q, mid_q;
	logic [IDX_W-1:0]       before_q, after_q;
	logic [TIME_W-1:0]      tb_q, ta_q;
	key_vec_t               va_q, vb_q;
	logic signed [COMP_W:0] diff_q [VEC_N];
	logic signed [TIME_W:0] num_q;
	logic [TIME_W-1:0]      den_q;
	logic [TIME_W-1:0]      rem_q;
	logic [FRAC_BITS:0]     f_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]       cnt_q;

	// staged result and output register
	logic             res_vres_q;
	logic [IDX_W-1:0] res_before_q, res_after_q;
	key_vec_t         res_vec_q;
	logic             out_valid_q;
	logic             out_vres_q;
	logic [KIDX_W-1:0] out_before_q, out_after_q;
	key_vec_t         out_vec_q;

	// combinational helpers
	logic              acc;
	logic              is_write;
	logic              empty;
	logic [IDX_W-1:0]  last_idx;
	logic              srch_ge;
	logic [IDX_W-1:0]  nlo, nhi, span, nmid, nbefore;
	logic              srch_done;
	logic              same_time;
	logic [TIME_W:0]   den_raw, num_raw;
	logic              den_neg;
	logic [TIME_W:0]   rem_sh;
	logic              div_ge;
	logic              out_free;
	logic [LANE_W-1:0] mul_lane, add_lane;
	logic signed [PROD_W-1:0] mul_res;

	assign item.ready = (state_q == S_IDLE);
	assign acc        = item.valid && item.ready;
	assign is_write   = (item.op == OP_WRITE);

	assign empty    = (key_count_q == '0);
	assign last_idx = (32'(key_count_q) > KEY_DEPTH) ? IDX_W'(KEY_DEPTH - 1)
		: IDX_W'(key_count_q - KCNT_W'(1));

	// one search step on the time read back at mid
	assign srch_ge   = (t_q >= rd_time_q);
	assign nlo       = srch_ge ? mid_q : lo_q;
	assign nhi       = srch_ge ? hi_q : mid_q;
	assign span      = nhi - nlo;
	assign srch_done = (span <= IDX_W'(1));
	assign nmid      = nlo + (span >> 1);
	assign nbefore   = (nhi != '0) ? nhi - IDX_W'(1) : '0;

	assign same_time = (ta_q == tb_q);
	assign den_raw   = {1'b0, ta_q} - {1'b0, tb_q};
	assign num_raw   = {1'b0, t_q} - {1'b0, tb_q};
	assign den_neg   = den_raw[TIME_W];

	assign rem_sh = {rem_q, 1'b0};
	assign div_ge = (rem_sh >= {1'b0, den_q});

	assign mul_lane = cnt_q[LANE_W-1:0];
	assign add_lane = LANE_W'(cnt_q - CNT_W'(1));
	assign mul_res  = PROD_W'(diff_q[mul_lane]) * PROD_W'(signed'({1'b0, f_q}));

	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = last_idx >> 1;
			S_SRCH:  rd_addr = srch_done ? nbefore : nmid;
			S_RDA:   rd_addr = after_q;
			default: rd_addr = before_q;
		endcase
	end

	// tables: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (acc && is_write && (32'(item.key_index) < KEY_DEPTH)) begin
			time_mem[IDX_W'(item.key_index)] <= item.key_time;
			vec_mem[IDX_W'(item.key_index)]  <= {item.key_z, item.key_y, item.key_x};
		end
		rd_time_q <= time_mem[rd_addr];
		rd_vec_q  <= vec_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			interp_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_COUNT: key_count_q <= cfg_wdata[KCNT_W-1:0];
				REG_INTERP_EN: interp_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					t_q          <= item.sample_time;
					lo_q         <= '0;
					hi_q         <= last_idx;
					mid_q        <= last_idx >> 1;
					res_vres_q   <= 1'b0;
					res_before_q <= '0;
					res_after_q  <= '0;
					res_vec_q    <= '0;
				end
			end
			S_SRCH: begin
				lo_q  <= nlo;
				hi_q  <= nhi;
				mid_q <= nmid;
				if (srch_done) begin
					before_q     <= nbefore;
					after_q      <= nhi;
					res_vres_q   <= 1'b1;
					res_before_q <= nbefore;
					res_after_q  <= nhi;
				end
			end
			S_RDA: begin
				tb_q <= rd_time_q;
				va_q <= rd_vec_q;
			end
			S_LATA: begin
				ta_q <= rd_time_q;
				vb_q <= rd_vec_q;
			end
			S_PREP: begin
				// make the denominator positive, flipping the numerator with it
				den_q <= den_neg ? TIME_W'(-den_raw) : den_raw[TIME_W-1:0];
				num_q <= den_neg ? signed'(-num_raw) : signed'(num_raw);
				for (int j = 0; j < VEC_N; j++) begin
					diff_q[j] <= signed'({vb_q[j][COMP_W-1], vb_q[j]})
						- signed'({va_q[j][COMP_W-1], va_q[j]});
				end
				if (!interp_q || same_time) res_vec_q <= va_q;
			end
			S_CLAMP: begin
				rem_q <= num_q[TIME_W-1:0];
				if (num_q[TIME_W] || num_q == '0) begin
					f_q <= '0;
				end else if (num_q >= signed'({1'b0, den_q})) begin
					f_q <= (FRAC_BITS+1)'(1) << FRAC_BITS;
				end else begin
					f_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= div_ge ? TIME_W'(rem_sh - {1'b0, den_q}) : rem_sh[TIME_W-1:0];
				f_q   <= {f_q[FRAC_BITS-1:0], div_ge};
			end
			S_MUL: begin
				if (cnt_q < CNT_W'(VEC_N)) prod_q <= mul_res;
				if (cnt_q != '0) begin
					res_vec_q[add_lane] <= va_q[add_lane] + COMP_W'(prod_q >>> FRAC_BITS);
				end
			end
			default: ;
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_vres_q   <= 1'b0;
			out_before_q <= '0;
			out_after_q  <= '0;
			out_vec_q    <= '0;
		end else begin
			if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (result.ready)            out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (is_write || empty) state_q <= S_FIN;
						else                   state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (srch_done) state_q <= S_RDA;
				end
				S_RDA: state_q <= S_LATA;
				S_LATA: state_q <= S_PREP;
				S_PREP: begin
					if (!interp_q || same_time) state_q <= S_FIN;
					else                        state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					cnt_q <= '0;
					if (num_q[TIME_W] || num_q == '0 || num_q >= signed'({1'b0, den_q}))
						state_q <= S_MUL;
					else
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(VEC_N)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_vres_q   <= res_vres_q;
						out_before_q <= KIDX_W'(res_before_q);
						out_after_q  <= KIDX_W'(res_after_q);
						out_vec_q    <= res_vec_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.valid_res    = out_vres_q;
	assign result.before_index = out_before_q;
	assign result.after_index  = out_after_q;
	assign result.out_x        = signed'(out_vec_q[0]);
	assign result.out_y        = signed'(out_vec_q[1]);
	assign result.out_z        = signed'(out_vec_q[2]);

endmodule

// ----- hw/rtl/kti_checker.sv -----
// port-level checks of the keyframe track interpolator and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kti_checker import kti_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     valid_res,
	input logic [KIDX_W-1:0]        before_index,
	input logic [KIDX_W-1:0]        after_index,
	input logic signed [COMP_W-1:0] out_x,
	input logic signed [COMP_W-1:0] out_y,
	input logic signed [COMP_W-1:0] out_z
);

	// one item at a time: taking a beat closes the input
	`KTI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a beat")

	// a stalled result beat holds its vector and before_index
	`KTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(before_index), "result changed while stalled")

	// writes and empty-track queries return an all-zero result
	`KTI_ASSERT_NOW(a_zero_result, out_valid && !valid_res, before_index == '0 && after_index == '0 && out_x == '0 && out_y == '0 && out_z == '0, "invalid result is not all zero")

	// bracketing keys are the same key at index zero or adjacent keys
	`KTI_ASSERT_NOW(a_bracket_pair, out_valid && valid_res, (after_index == '0 && before_index == '0) || (after_index == before_index + KIDX_W'(1)), "bracketing keys not adjacent")

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.valid_res    (result.valid_res),
	.before_index (result.before_index),
	.after_index  (result.after_index),
	.out_x        (result.out_x),
	.out_y        (result.out_y),
	.out_z        (result.out_z)
);
